>>> rtl/core/hse_pkg.sv
// Shared constants, tables, types and functions of the Hamming SEC encoder and decoder.
package hse_pkg;

  localparam int MAX_CODE_BITS = 64;
  localparam int WORD_W        = 64;
  localparam int SYN_W         = 7;
  localparam int MSG_REG_W     = 6;
  localparam int IDX_W         = $clog2(WORD_W);

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic [MSG_REG_W-1:0] RESET_MSG_BITS = MSG_REG_W'(4);

  // Smallest r with m + 1 + r <= 2^r.
  function automatic logic [SYN_W-1:0] parity_bits(logic [SYN_W-1:0] m);
    logic [SYN_W:0] r;
    r = (SYN_W+1)'(1);
    for (int i = 0; i < SYN_W; i++) begin
      if (({1'b0, m} + r + (SYN_W+1)'(1)) > ((SYN_W+1)'(1) << r)) begin
        r = r + (SYN_W+1)'(1);
      end
    end
    return r[SYN_W-1:0];
  endfunction

  // Longest message whose code still fits in MAX_CODE_BITS.
  function automatic int max_msg_bits();
    int best;
    best = 1;
    for (int m = 1; m < (1 << MSG_REG_W); m++) begin
      if (m + int'(parity_bits(SYN_W'(m))) <= MAX_CODE_BITS) begin
        best = m;
      end
    end
    return best;
  endfunction

  localparam int MSG_MAX = max_msg_bits();

  typedef logic [MSG_MAX-1:0][SYN_W-1:0] pos_tab_t;
  typedef logic [SYN_W-1:0][WORD_W-1:0]  cover_tab_t;

  // Code position of each message bit: the non-power-of-two positions in rising order.
  function automatic pos_tab_t build_data_pos();
    pos_tab_t tab;
    int k;
    tab = '0;
    k = 0;
    for (int p = 1; p <= MAX_CODE_BITS; p++) begin
      if (((p & (p - 1)) != 0) && (k < MSG_MAX)) begin
        tab[k] = SYN_W'(p);
        k++;
      end
    end
    return tab;
  endfunction

  // Row i marks every code position whose number has bit i set.
  function automatic cover_tab_t build_cover();
    cover_tab_t tab;
    tab = '0;
    for (int i = 0; i < SYN_W; i++) begin
      for (int p = 1; p <= MAX_CODE_BITS; p++) begin
        if (((p >> i) & 1) != 0) begin
          tab[i][p-1] = 1'b1;
        end
      end
    end
    return tab;
  endfunction

  localparam pos_tab_t   DATA_POS = build_data_pos();
  localparam cover_tab_t COVER    = build_cover();

  typedef struct packed {
    logic [SYN_W-1:0]  code_len;
    logic [WORD_W-1:0] msg_mask;
    logic [WORD_W-1:0] code_mask;
  } code_cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] code_word;
    logic [SYN_W-1:0]  syndrome;
    logic              corrected;
    logic              out_of_range;
  } result_t;

  // Clamp the written length and derive the code length and masks.
  function automatic code_cfg_t derive_cfg(logic [MSG_REG_W-1:0] msg_bits);
    code_cfg_t        c;
    logic [SYN_W-1:0] m;
    m = SYN_W'(msg_bits);
    if (m == '0) begin
      m = SYN_W'(1);
    end else if (m > SYN_W'(MSG_MAX)) begin
      m = SYN_W'(MSG_MAX);
    end
    c.code_len  = m + parity_bits(m);
    c.msg_mask  = ~({WORD_W{1'b1}} << m);
    c.code_mask = ~({WORD_W{1'b1}} << c.code_len);
    return c;
  endfunction

endpackage

>>> rtl/core/hse_cfg.sv
// Message length register with the derived code length and masks.
module hse_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           message_bits_we,
  input  logic [hse_pkg::MSG_REG_W-1:0]  message_bits,
  output hse_pkg::code_cfg_t             cfg
);
  import hse_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= derive_cfg(RESET_MSG_BITS);
    end else if (message_bits_we) begin
      cfg <= derive_cfg(message_bits);
    end
  end

endmodule

>>> rtl/core/hse_datapath.sv
// Parity trees for encoding and syndrome decoding with single-bit correction.
module hse_datapath (
  input  logic                        kind,
  input  logic [hse_pkg::WORD_W-1:0]  payload,
  input  hse_pkg::code_cfg_t          cfg,
  output hse_pkg::result_t            result
);
  import hse_pkg::*;

  logic [WORD_W-1:0] msg;
  logic [WORD_W-1:0] spread;
  logic [WORD_W-1:0] enc_word;
  logic [WORD_W-1:0] rx_word;
  logic [SYN_W-1:0]  syn;
  logic              beyond;
  logic              fix;
  logic [SYN_W-1:0]  flip_pos;
  logic [WORD_W-1:0] flip;

  // Scatter message bits to their fixed code positions.
  always_comb begin
    logic [SYN_W-1:0] at;
    msg    = payload & cfg.msg_mask;
    spread = '0;
    for (int k = 0; k < MSG_MAX; k++) begin
      at = DATA_POS[k] - SYN_W'(1);
      spread[at[IDX_W-1:0]] = msg[k];
    end
  end

  always_comb begin
    enc_word = spread;
    for (int i = 0; i < SYN_W; i++) begin
      if ((1 << i) <= MAX_CODE_BITS) begin
        enc_word[IDX_W'((1 << i) - 1)] = ^(spread & COVER[i]);
      end
    end
  end

  always_comb begin
    rx_word = payload & cfg.code_mask;
    for (int i = 0; i < SYN_W; i++) begin
      syn[i] = ^(rx_word & COVER[i]);
    end
  end

  assign beyond   = (syn > cfg.code_len);
  assign fix      = !beyond && (syn != '0);
  assign flip_pos = syn - SYN_W'(1);
  assign flip     = fix ? ({{(WORD_W-1){1'b0}}, 1'b1} << flip_pos[IDX_W-1:0]) : '0;

  always_comb begin
    if (kind == KIND_DECODE) begin
      result.code_word    = (rx_word ^ flip) & cfg.code_mask;
      result.syndrome     = syn;
      result.corrected    = fix;
      result.out_of_range = beyond;
    end else begin
      result.code_word    = enc_word & cfg.code_mask;
      result.syndrome     = '0;
      result.corrected    = 1'b0;
      result.out_of_range = 1'b0;
    end
  end

endmodule

>>> rtl/core/hamming_sec_encode_decode.sv
// Top level of the configurable Hamming single-error-correcting encoder and decoder.

// Each word is either a message to encode (kind 0) or a received codeword to check
// and correct (kind 1). A word is registered at the input, passes through the parity
// trees and lands in the output register once that register is empty or being drained,
// which raises out_valid; the result stays there until out_ready takes it. One word is
// taken every cycle while the consumer keeps out_ready high. A single parity-tree stage
// lies between the input and output registers. The message length is written through
// message_bits_we and message_bits; it resets to 4 (a 7-bit code) and must only change
// while no word is in flight. Lengths of zero read as one, and lengths whose code would
// not fit in 64 bits are lowered to 57.
module hamming_sec_encode_decode (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            message_bits_we,
  input  logic [hse_pkg::MSG_REG_W-1:0]   message_bits,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [hse_pkg::WORD_W-1:0]      payload,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hse_pkg::WORD_W-1:0]      code_word,
  output logic [hse_pkg::SYN_W-1:0]       syndrome,
  output logic                            corrected,
  output logic                            syndrome_out_of_range
);
  import hse_pkg::*;

  code_cfg_t         cfg;
  result_t           result;

  logic              s1_valid;
  logic              s1_valid_next;
  logic              s1_kind;
  logic [WORD_W-1:0] s1_payload;
  logic              out_kind;
  logic              out_valid_next;
  logic              in_take;
  logic              out_load;

  hse_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .message_bits_we (message_bits_we),
    .message_bits    (message_bits),
    .cfg             (cfg)
  );

  hse_datapath u_datapath (
    .kind    (s1_kind),
    .payload (s1_payload),
    .cfg     (cfg),
    .result  (result)
  );

  // The output register moves whenever it is empty or being drained, and the input
  // register frees up whenever its word moves on, so a full pipe keeps flowing.
  assign out_load       = s1_valid && (!out_valid || out_ready);
  assign in_ready       = !s1_valid || !out_valid || out_ready;
  assign in_take        = in_valid && in_ready;
  assign s1_valid_next  = in_take || (s1_valid && !out_load);
  assign out_valid_next = out_load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers carry no reset; their valid bits gate them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind    <= kind;
      s1_payload <= payload;
    end
    if (out_load) begin
      out_kind              <= s1_kind;
      code_word             <= result.code_word;
      syndrome              <= result.syndrome;
      corrected             <= result.corrected;
      syndrome_out_of_range <= result.out_of_range;
    end
  end

  // An encoded word never reports an error.
  a_encode_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_ENCODE)) |->
      ((syndrome == '0) && !corrected && !syndrome_out_of_range))
    else $error("encode result carries error status");

  // A correction points inside the code and excludes the out-of-range flag.
  a_fix_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && corrected) |->
      ((syndrome != '0) && (syndrome <= cfg.code_len) && !syndrome_out_of_range))
    else $error("correction at an impossible position");

  // Nothing is ever driven above the code length.
  a_word_masked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((code_word & ~cfg.code_mask) == '0))
    else $error("code word has bits above the code length");

  // A word held in the input register behind a stalled output is not dropped.
  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> (s1_valid && out_valid))
    else $error("word lost while the output was stalled");

endmodule

>>> sim/hamming_sec_encode_decode_tb.sv
// Self-checking testbench for the configurable Hamming SEC encoder and decoder.
module hamming_sec_encode_decode_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here if the result stream stalls for good.
  localparam int unsigned RUN_LIMIT = 200000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int LONG_HOLD = 80;
  localparam int PHASES    = 12;
  localparam int PHASE_WORDS = 46;

  // One expected or observed result word, field for field as on the ports.
  typedef struct packed {
    logic [hse_pkg::WORD_W-1:0] code_word;
    logic [hse_pkg::SYN_W-1:0]  syndrome;
    logic                       corrected;
    logic                       out_of_range;
  } word_result_t;

  // Holds the current message length, computes the Hamming result of every
  // accepted word and keeps those results in order until the block emits them.
  class hamming_ledger;
    int unsigned msg_len;
    int unsigned code_len;
    logic [63:0] code_mask;
    word_result_t awaited_results[$];
    int errors  = 0;
    int encoded = 0;
    int decoded = 0;
    int fixes   = 0;
    int beyond  = 0;

    function new();
      set_length(hse_pkg::RESET_MSG_BITS);
    endfunction

    // Smallest r with m + 1 + r <= 2^r.
    function int unsigned parity_len(int unsigned m);
      int unsigned r;
      r = 1;
      while (m + 1 + r > (1 << r)) r++;
      return r;
    endfunction

    function void set_length(logic [hse_pkg::MSG_REG_W-1:0] value);
      int unsigned m;
      m = (value == 0) ? 1 : value;
      while (m > 1 && m + parity_len(m) > hse_pkg::MAX_CODE_BITS) m--;
      msg_len   = m;
      code_len  = m + parity_len(m);
      code_mask = (code_len >= 64) ? '1 : (64'd1 << code_len) - 64'd1;
    endfunction

    // XOR of the position numbers of every set bit inside the code.
    function int unsigned position_xor(logic [63:0] w);
      int unsigned s;
      s = 0;
      for (int unsigned p = 1; p <= code_len; p++) begin
        if (w[p-1]) s ^= p;
      end
      return s;
    endfunction

    function word_result_t hamming_result(logic k, logic [63:0] p);
      word_result_t res;
      logic [63:0]  w;
      int unsigned  idx;
      int unsigned  s;
      res = '0;
      w   = '0;
      idx = 0;
      if (k == hse_pkg::KIND_ENCODE) begin
        // Message bits go to the non-power-of-two positions, lowest first.
        for (int unsigned pos = 1; pos <= code_len; pos++) begin
          if ((pos & (pos - 1)) != 0) begin
            w[pos-1] = p[idx];
            idx++;
          end
        end
        // Setting the parity bits from the data syndrome drives it to zero.
        s = position_xor(w);
        for (int unsigned b = 1; b <= code_len; b <<= 1) begin
          if ((s & b) != 0) w[b-1] = 1'b1;
        end
      end else begin
        w = p & code_mask;
        s = position_xor(w);
        res.syndrome = hse_pkg::SYN_W'(s);
        if (s > code_len) begin
          res.out_of_range = 1'b1;
        end else if (s != 0) begin
          w[s-1] = ~w[s-1];
          res.corrected = 1'b1;
        end
      end
      res.code_word = w & code_mask;
      return res;
    endfunction

    function void note_word(logic k, logic [63:0] p);
      word_result_t res;
      res = hamming_result(k, p);
      awaited_results.push_back(res);
      if (k == hse_pkg::KIND_DECODE) begin
        decoded++;
        fixes  += res.corrected;
        beyond += res.out_of_range;
      end else begin
        encoded++;
      end
    endfunction

    function void check_word(word_result_t got);
      word_result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none pending: code_word %h syndrome %0d",
                 $time, got.code_word, got.syndrome);
        return;
      end
      want = awaited_results.pop_front();
      if (got.code_word !== want.code_word) begin
        errors++;
        $display("%0t: code_word expected %h actual %h", $time, want.code_word,
                 got.code_word);
      end
      if (got.syndrome !== want.syndrome) begin
        errors++;
        $display("%0t: syndrome expected %0d actual %0d", $time, want.syndrome,
                 got.syndrome);
      end
      if (got.corrected !== want.corrected) begin
        errors++;
        $display("%0t: corrected expected %b actual %b", $time, want.corrected,
                 got.corrected);
      end
      if (got.out_of_range !== want.out_of_range) begin
        errors++;
        $display("%0t: syndrome_out_of_range expected %b actual %b", $time,
                 want.out_of_range, got.out_of_range);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           message_bits_we = 1'b0;
  logic [hse_pkg::MSG_REG_W-1:0]  message_bits = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           kind = hse_pkg::KIND_ENCODE;
  logic [hse_pkg::WORD_W-1:0]     payload = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [hse_pkg::WORD_W-1:0]     code_word;
  logic [hse_pkg::SYN_W-1:0]      syndrome;
  logic                           corrected;
  logic                           syndrome_out_of_range;

  hamming_ledger ledger = new();

  // While calm is set the sender inserts no idle cycles and the receiver starts no random stalls.
  bit          calm = 1'b0;
  // The stimulus bumps the request count; the receiver serves each one with
  // one long hold-off that it times itself.
  int          backlog_requests = 0;
  int          backlog_served   = 0;
  int          hold_left        = 0;
  int unsigned cycles           = 0;

  hamming_sec_encode_decode i_dut (
    .clk                   (clk),
    .rst                   (rst),
    .message_bits_we       (message_bits_we),
    .message_bits          (message_bits),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .kind                  (kind),
    .payload               (payload),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .code_word             (code_word),
    .syndrome              (syndrome),
    .corrected             (corrected),
    .syndrome_out_of_range (syndrome_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a run that never drains is a failure, not a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("hamming_sec_encode_decode verification failed");
      $finish;
    end
  end

  // Receiver pacing. A pending backlog request wins once any running hold-off ends and
  // holds out_ready low for a long hold-off, so the block fills up and must drop in_ready.
  // Otherwise it is mostly ready, with single-cycle stalls and the odd longer one.
  always @(posedge clk) begin : receiver_pace
    int pick;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (backlog_requests != backlog_served) begin
      out_ready      <= 1'b0;
      hold_left      <= LONG_HOLD - 1;
      backlog_served <= backlog_served + 1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        out_ready <= 1'b1;
      end else if (pick < 95) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(8, 25);
      end
    end
  end

  // Every word leaving the block is checked against the oldest expectation.
  // The sampled values are the ones the block presented at this edge.
  always @(posedge clk) begin : result_monitor
    word_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.code_word    = code_word;
      got.syndrome     = syndrome;
      got.corrected    = corrected;
      got.out_of_range = syndrome_out_of_range;
      ledger.check_word(got);
    end
  end

  // Sender idle length: mostly none, some short gaps, a few long ones.
  function automatic int pick_gap();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid is only
  // dropped when an idle gap follows, so back-to-back words keep it high.
  task automatic send_word(input logic k, input logic [63:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    payload  <= p;
    do @(posedge clk); while (!in_ready);
    ledger.note_word(k, p);
  endtask

  // The length only changes with nothing in flight: wait for the last result,
  // give the pipeline a few more cycles, then write the register for one edge.
  task automatic set_length(input logic [hse_pkg::MSG_REG_W-1:0] value);
    in_valid <= 1'b0;
    while (ledger.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    message_bits_we <= 1'b1;
    message_bits    <= value;
    @(posedge clk);
    message_bits_we <= 1'b0;
    ledger.set_length(value);
  endtask

  // Random traffic at the current length. Most of it is an encode followed by a
  // decode of that very codeword, either clean, with one flipped bit, with two
  // flipped bits, or with one flipped bit and junk above the code end. The rest is
  // raw words of either kind, which also reach syndromes past the code end.
  task automatic run_phase(input int words, input bit back_up);
    int           sent;
    int           pick;
    int           flaw;
    int unsigned  n;
    logic [63:0]  msg;
    logic [63:0]  cw;
    word_result_t enc;
    sent = 0;
    n    = ledger.code_len;
    while (sent < words) begin
      if (back_up && sent == 10) backlog_requests++;
      pick = $urandom_range(0, 99);
      msg  = {$urandom, $urandom};
      if (pick < 60) begin
        send_word(hse_pkg::KIND_ENCODE, msg);
        enc  = ledger.hamming_result(hse_pkg::KIND_ENCODE, msg);
        cw   = enc.code_word;
        flaw = $urandom_range(0, 9);
        if (flaw >= 3) cw[$urandom_range(0, n - 1)] ^= 1'b1;
        if (flaw == 8) cw[$urandom_range(0, n - 1)] ^= 1'b1;
        if (flaw == 9 && n < 64) cw |= {$urandom, $urandom} & ~ledger.code_mask;
        send_word(hse_pkg::KIND_DECODE, cw);
        sent += 2;
      end else if (pick < 80) begin
        send_word(hse_pkg::KIND_DECODE, msg);
        sent++;
      end else begin
        send_word(hse_pkg::KIND_ENCODE, msg);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int           lengths [PHASES];
    word_result_t enc;
    logic [63:0]  cw;

    // Zero and the over-long settings exercise the clamping; 63 and 0 between
    // them toggle every register bit; 57 is the longest message whose code fits.
    lengths = '{0, 1, 2, 63, 57, 11, 26, 58, 3, 40, 0, 0};
    lengths[10] = $urandom_range(0, 63);
    lengths[11] = $urandom_range(0, 63);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset length of four message bits, a 7-bit code.
    send_word(hse_pkg::KIND_ENCODE, 64'd0);
    send_word(hse_pkg::KIND_ENCODE, 64'hF);
    // Message bits above the length must be ignored.
    send_word(hse_pkg::KIND_ENCODE, '1);
    for (int b = 0; b < 4; b++) send_word(hse_pkg::KIND_ENCODE, 64'd1 << b);
    send_word(hse_pkg::KIND_DECODE, 64'd0);
    send_word(hse_pkg::KIND_DECODE, '1);
    // A single error at every code position, including each parity bit.
    enc = ledger.hamming_result(hse_pkg::KIND_ENCODE, 64'hB);
    cw  = enc.code_word;
    for (int p = 0; p < 7; p++) send_word(hse_pkg::KIND_DECODE, cw ^ (64'd1 << p));
    // Received bits above the code end must read as zero.
    send_word(hse_pkg::KIND_DECODE, cw | 64'hFFFF_FFFF_FFFF_FF80);

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = 1'b0;
      set_length(hse_pkg::MSG_REG_W'(lengths[ph]));
      calm = (ph % 4 == 3);
      run_phase(PHASE_WORDS, ph % 3 == 0);
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (ledger.awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d encodes and %0d decodes over %0d length settings,",
             ledger.encoded, ledger.decoded, PHASES + 1);
    $display("including %0d single-bit corrections and %0d syndromes past the code end.",
             ledger.fixes, ledger.beyond);
    if (ledger.errors == 0) begin
      $display("hamming_sec_encode_decode verification clean");
    end else begin
      $display("hamming_sec_encode_decode verification failed");
    end
    $finish;
  end

endmodule
